@@ rtl/dns_query_allowlist_filter_macros.svh @@
// assertion macros for the dns query allowlist filter
// used by dqaf_parser through `include, no other dependencies
`ifndef DNS_QUERY_ALLOWLIST_FILTER_MACROS_SVH
`define DNS_QUERY_ALLOWLIST_FILTER_MACROS_SVH

`ifndef SYNTHESIS

`define DQAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqaf check failed");

`define DQAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqaf check failed");

`else

`define DQAF_ASSERT_NOW(label, clk, rst, ante, cons)

`define DQAF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/dqaf_pkg.sv @@
// shared types, constants and allowlist rom for the dns query allowlist filter
// no dependencies
package dqaf_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 512;
   localparam int NAME_CHARS_MAX_DEF   = 128;
   localparam int ALLOWED_ENTRIES_DEF  = 13;

   localparam int HEADER_BYTES   = 12;
   localparam int QCOUNT_HI_POS  = 4;
   localparam int QCOUNT_LO_POS  = 5;
   localparam int TAIL_BYTES     = 4;
   localparam int ANSWER_BYTES   = 16;
   localparam int REPLY_LIMIT    = 512;
   localparam int ROM_ROWS       = 13;
   localparam int ROW_CHARS      = 32;
   localparam int VERDICT_W      = 3;
   localparam int QEND_W         = 10;
   localparam int ENTRY_W        = 4;

   localparam logic [7:0] POINTER_MARK = 8'hC0;
   localparam logic [7:0] DOT_CHAR     = 8'h2E;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ANSWER       = 3'd0,
      VERDICT_SHORT_HEADER = 3'd1,
      VERDICT_QCOUNT       = 3'd2,
      VERDICT_BAD_NAME     = 3'd3,
      VERDICT_INCOMPLETE   = 3'd4,
      VERDICT_NOT_ALLOWED  = 3'd5,
      VERDICT_TOO_LONG     = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      verdict_type         verdict;
      logic [QEND_W-1:0]   question_end;
      logic [ENTRY_W-1:0]  matched_entry;
   } result_type;

   // rows are right aligned, first character in the highest used byte of the row
   localparam logic [ROW_CHARS*8-1:0] ALLOW_ROM [ROM_ROWS] = '{
      256'h64_65_76_69_63_65_2e_6c_6f_63_61_6c,
      256'h77_77_77_2e_64_65_76_69_63_65_2e_6c_6f_63_61_6c,
      256'h70_6f_72_74_61_6c_2e_6c_6f_63_61_6c,
      256'h65_73_70_33_32_2e_6c_6f_63_61_6c,
      256'h63_6f_6e_6e_65_63_74_69_76_69_74_79_63_68_65_63_6b_2e_67_73_74_61_74_69_63_2e_63_6f_6d,
      256'h63_6f_6e_6e_65_63_74_69_76_69_74_79_63_68_65_63_6b_2e_61_6e_64_72_6f_69_64_2e_63_6f_6d,
      256'h63_6c_69_65_6e_74_73_33_2e_67_6f_6f_67_6c_65_2e_63_6f_6d,
      256'h63_61_70_74_69_76_65_2e_61_70_70_6c_65_2e_63_6f_6d,
      256'h77_77_77_2e_61_70_70_6c_65_2e_63_6f_6d,
      256'h61_70_70_6c_65_2e_63_6f_6d,
      256'h77_77_77_2e_6d_73_66_74_63_6f_6e_6e_65_63_74_74_65_73_74_2e_63_6f_6d,
      256'h77_77_77_2e_6d_73_66_74_6e_63_73_69_2e_63_6f_6d,
      256'h6d_73_66_74_63_6f_6e_6e_65_63_74_74_65_73_74_2e_63_6f_6d
   };

   localparam logic [4:0] ROW_LEN [ROM_ROWS] = '{
      5'd12, 5'd16, 5'd12, 5'd11, 5'd29, 5'd29, 5'd19,
      5'd17, 5'd13, 5'd9, 5'd23, 5'd16, 5'd19
   };

   function automatic logic [4:0] rom_len(input logic [3:0] row);
      return ROW_LEN[row];
   endfunction

   function automatic logic [7:0] rom_char(input logic [3:0] row, input logic [4:0] col);
      logic [4:0] off;
      off = ROW_LEN[row] - 5'd1 - col;
      return ALLOW_ROM[row][{off, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

endpackage

@@ rtl/dns_query_allowlist_filter.sv @@
// DNS query allowlist filter, top level; uses dqaf_pkg, dqaf_in_stage, dqaf_parser and
// dqaf_out_stage. Takes a query datagram one byte per transaction on the req_ channel and
// gives one transaction on the rsp_ channel per datagram, after its last byte. A byte is
// accepted every cycle: each byte goes through an input register, one pass of the parser
// with its per-entry compare lanes, and on the last byte into the result register, from
// which the verdict is presented. Only a stalled result holds up the input, and only once
// the input register is full as well. No warm-up after reset.
module dns_query_allowlist_filter #(
   parameter int MAX_PACKET_BYTES = dqaf_pkg::MAX_PACKET_BYTES_DEF,
   parameter int NAME_CHARS_MAX   = dqaf_pkg::NAME_CHARS_MAX_DEF,
   parameter int ALLOWED_ENTRIES  = dqaf_pkg::ALLOWED_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_packet_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dqaf_pkg::VERDICT_W-1:0] rsp_verdict,
   output logic [dqaf_pkg::QEND_W-1:0]    rsp_question_end,
   output logic [dqaf_pkg::ENTRY_W-1:0]   rsp_matched_entry
);

   logic                 advance;
   logic                 item_valid;
   dqaf_pkg::item_type   item;
   dqaf_pkg::result_type result;

   dqaf_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packet_byte (req_packet_byte),
      .req_last_byte   (req_last_byte),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   dqaf_parser #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .NAME_CHARS_MAX   (NAME_CHARS_MAX),
      .ALLOWED_ENTRIES  (ALLOWED_ENTRIES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .result     (result)
   );

   dqaf_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (item_valid && item.last_byte),
      .result            (result),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_question_end  (rsp_question_end),
      .rsp_matched_entry (rsp_matched_entry)
   );

endmodule

@@ rtl/dqaf_in_stage.sv @@
// input register for the dns query allowlist filter
// depends on dqaf_pkg
module dqaf_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_packet_byte,
   input  logic              req_last_byte,
   input  logic              advance,
   output logic              item_valid,
   output dqaf_pkg::item_type item
);

   logic               valid_ff, valid_in;
   dqaf_pkg::item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.packet_byte <= req_packet_byte;
         item_ff.last_byte   <= req_last_byte;
      end
   end

endmodule

@@ rtl/dqaf_parser.sv @@
// per-byte header and name parser with parallel allowlist lanes and verdict logic
// depends on dqaf_pkg and dns_query_allowlist_filter_macros.svh
`include "dns_query_allowlist_filter_macros.svh"

module dqaf_parser #(
   parameter int MAX_PACKET_BYTES = dqaf_pkg::MAX_PACKET_BYTES_DEF,
   parameter int NAME_CHARS_MAX   = dqaf_pkg::NAME_CHARS_MAX_DEF,
   parameter int ALLOWED_ENTRIES  = dqaf_pkg::ALLOWED_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  dqaf_pkg::item_type   item,
   input  logic                 advance,
   output dqaf_pkg::result_type result
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CNT_W = $clog2(NAME_CHARS_MAX);
   localparam int EXT_W = ((POS_W > dqaf_pkg::QEND_W) ? POS_W : dqaf_pkg::QEND_W) + 1;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LENGTH = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_TAIL   = 5'b01000,
      PH_STOP   = 5'b10000
   } phase_type;

   logic [POS_W-1:0]           pos_ff, pos_in, pos_nx;
   phase_type                  phase_ff, phase_in, phase_nx;
   logic [7:0]                 left_ff, left_in, left_nx;
   logic [CNT_W-1:0]           count_ff, count_in, count_nx;
   logic [ALLOWED_ENTRIES-1:0] mask_ff, mask_in, mask_nx;
   logic                       ended_ff, ended_in, ended_nx;
   logic [15:0]                qc_ff, qc_in, qc_nx;
   logic [POS_W-1:0]           neo_ff, neo_in, neo_nx;
   logic                       malformed_ff, malformed_in, malformed_nx;

   logic                       upd;
   logic                       push_en;
   logic [7:0]                 push_c;
   logic [ALLOWED_ENTRIES-1:0] keep;
   logic [ALLOWED_ENTRIES-1:0] hit;
   logic [7:0]                 b;

   assign upd    = item_valid && advance;
   assign b      = item.packet_byte;
   // a length byte only ever pushes the dot separator
   assign push_c = (phase_ff == PH_LENGTH) ? dqaf_pkg::DOT_CHAR : b;

   // one compare lane per allowlist entry
   for (genvar i = 0; i < ALLOWED_ENTRIES; i++) begin : g_lane
      if (i < dqaf_pkg::ROM_ROWS) begin : g_rom
         assign keep[i] = (count_ff < CNT_W'(dqaf_pkg::rom_len(4'(i))))
            && (dqaf_pkg::fold_case(push_c) == dqaf_pkg::rom_char(4'(i), count_ff[4:0]));
         assign hit[i] = mask_nx[i] && (count_nx == CNT_W'(dqaf_pkg::rom_len(4'(i))));
      end else begin : g_none
         assign keep[i] = 1'b0;
         assign hit[i]  = 1'b0;
      end
   end

   always_comb begin
      pos_nx       = pos_ff;
      phase_nx     = phase_ff;
      left_nx      = left_ff;
      count_nx     = count_ff;
      mask_nx      = mask_ff;
      ended_nx     = ended_ff;
      qc_nx        = qc_ff;
      neo_nx       = neo_ff;
      malformed_nx = malformed_ff;
      push_en      = 1'b0;
      if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == POS_W'(dqaf_pkg::QCOUNT_HI_POS)) begin
                  qc_nx = {b, 8'h00};
               end else if (pos_ff == POS_W'(dqaf_pkg::QCOUNT_LO_POS)) begin
                  qc_nx = {qc_ff[15:8], b};
               end
               if (pos_ff == POS_W'(dqaf_pkg::HEADER_BYTES - 1)) begin
                  phase_nx = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (b == 8'h00) begin
                  neo_nx   = pos_ff + 1'b1;
                  phase_nx = PH_TAIL;
               end else if ((b & dqaf_pkg::POINTER_MARK) == dqaf_pkg::POINTER_MARK) begin
                  malformed_nx = 1'b1;
                  phase_nx     = PH_STOP;
               end else begin
                  push_en  = (count_ff != '0);
                  left_nx  = b;
                  phase_nx = PH_BODY;
               end
            end
            PH_BODY: begin
               push_en = 1'b1;
               if (left_ff != 8'd0) begin
                  left_nx = left_ff - 8'd1;
               end
               if (left_nx == 8'd0) begin
                  phase_nx = PH_LENGTH;
               end
            end
            PH_TAIL, PH_STOP: begin
            end
            default: begin
            end
         endcase
         pos_nx = pos_ff + 1'b1;
      end
      if (push_en && !ended_ff && (count_ff < CNT_W'(NAME_CHARS_MAX - 1))) begin
         if (push_c == 8'h00) begin
            ended_nx = 1'b1;
         end else begin
            mask_nx  = mask_ff & keep;
            count_nx = count_ff + 1'b1;
         end
      end
   end

   // verdict for a datagram that ends on this byte
   always_comb begin
      logic                         found;
      logic [dqaf_pkg::ENTRY_W-1:0] match;
      logic [EXT_W-1:0]             tail_end;
      logic [EXT_W-1:0]             reply_end;
      found     = 1'b0;
      match     = '0;
      tail_end  = EXT_W'(neo_nx) + EXT_W'(dqaf_pkg::TAIL_BYTES);
      reply_end = tail_end + EXT_W'(dqaf_pkg::ANSWER_BYTES);
      for (int i = ALLOWED_ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found = 1'b1;
            match = dqaf_pkg::ENTRY_W'(i);
         end
      end
      result.verdict       = dqaf_pkg::VERDICT_ANSWER;
      result.question_end  = '0;
      result.matched_entry = '0;
      priority if (pos_nx < POS_W'(dqaf_pkg::HEADER_BYTES)) begin
         result.verdict = dqaf_pkg::VERDICT_SHORT_HEADER;
      end else if (qc_nx != 16'd1) begin
         result.verdict = dqaf_pkg::VERDICT_QCOUNT;
      end else if (malformed_nx || phase_nx == PH_BODY) begin
         result.verdict = dqaf_pkg::VERDICT_BAD_NAME;
      end else if (phase_nx != PH_TAIL || tail_end > EXT_W'(pos_nx)) begin
         result.verdict = dqaf_pkg::VERDICT_INCOMPLETE;
      end else if (!found) begin
         result.verdict = dqaf_pkg::VERDICT_NOT_ALLOWED;
      end else if (reply_end > EXT_W'(dqaf_pkg::REPLY_LIMIT)) begin
         result.verdict = dqaf_pkg::VERDICT_TOO_LONG;
      end else begin
         result.question_end  = tail_end[dqaf_pkg::QEND_W-1:0];
         result.matched_entry = match;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      ended_in     = ended_ff;
      qc_in        = qc_ff;
      neo_in       = neo_ff;
      malformed_in = malformed_ff;
      if (upd) begin
         if (item.last_byte) begin
            pos_in       = '0;
            phase_in     = PH_HEADER;
            left_in      = '0;
            count_in     = '0;
            mask_in      = '1;
            ended_in     = 1'b0;
            qc_in        = '0;
            neo_in       = '0;
            malformed_in = 1'b0;
         end else begin
            pos_in       = pos_nx;
            phase_in     = phase_nx;
            left_in      = left_nx;
            count_in     = count_nx;
            mask_in      = mask_nx;
            ended_in     = ended_nx;
            qc_in        = qc_nx;
            neo_in       = neo_nx;
            malformed_in = malformed_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_HEADER;
         left_ff      <= '0;
         count_ff     <= '0;
         mask_ff      <= '1;
         ended_ff     <= 1'b0;
         qc_ff        <= '0;
         neo_ff       <= '0;
         malformed_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         ended_ff     <= ended_in;
         qc_ff        <= qc_in;
         neo_ff       <= neo_in;
         malformed_ff <= malformed_in;
      end
   end

   `DQAF_ASSERT_NEXT(a_reset_after_last, clock, reset, upd && item.last_byte, pos_ff == '0 && phase_ff == PH_HEADER && mask_ff == '1)
   `DQAF_ASSERT_NEXT(a_mask_only_clears, clock, reset, upd && !item.last_byte, (mask_ff & ~$past(mask_ff)) == '0)
   `DQAF_ASSERT_NOW(a_answer_qend_floor, clock, reset, upd && item.last_byte && result.verdict == dqaf_pkg::VERDICT_ANSWER, result.question_end >= dqaf_pkg::QEND_W'(dqaf_pkg::HEADER_BYTES + 1 + dqaf_pkg::TAIL_BYTES))
   `DQAF_ASSERT_NOW(a_pos_bounded, clock, reset, 1'b1, pos_ff <= POS_W'(MAX_PACKET_BYTES))

endmodule

@@ rtl/dqaf_out_stage.sv @@
// result register for the dns query allowlist filter
// depends on dqaf_pkg
module dqaf_out_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load_valid,
   input  dqaf_pkg::result_type                result,
   output logic                                advance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dqaf_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic [dqaf_pkg::QEND_W-1:0]         rsp_question_end,
   output logic [dqaf_pkg::ENTRY_W-1:0]        rsp_matched_entry
);

   logic                 valid_ff, valid_in;
   dqaf_pkg::result_type result_ff;

   assign advance           = !valid_ff || rsp_ready;
   assign valid_in          = advance ? load_valid : valid_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_verdict       = result_ff.verdict;
   assign rsp_question_end  = result_ff.question_end;
   assign rsp_matched_entry = result_ff.matched_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         result_ff <= result;
      end
   end

endmodule
